// ===== sv/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes of the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffba_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_ALLOC_SPLIT,
    ST_ALLOC_MARK,
    ST_FREE_MERGE,
    ST_QUERY_FIN,
    ST_RESP
  } ffba_state_t;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  localparam logic [14:0] MAX_BYTES_SAT = 15'd32767;

endpackage

// ===== sv/ffba_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffba_ram
// Generic one-write one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ffba_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffba_div
// Byte count to unit count for a power-of-two unit size, registered after start.
// ---------------------------------------------------------------------------
module ffba_div #(
  parameter int DIVISOR = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  output logic        done,
  output logic [15:0] quotient
);

  localparam int SHIFT = $clog2(DIVISOR);

  logic [15:0] q_r, q_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    done_nxt = start;
    q_nxt    = q_r;
    if (start) begin
      q_nxt = dividend >> SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== sv/first_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over an address-ordered block list with coalescing.
// ---------------------------------------------------------------------------
// One item is handled at a time. Block headers (length, free flag) sit in a
// single RAM indexed by block start unit; the list walk reads one block per
// cycle. An item is taken in idle, walks the list block by block (at most
// POOL_UNITS blocks), and then loads the result register. Allocate first turns
// the byte size into units (UNIT_BYTES must be a power of two) and then may
// write up to two headers; a valid free adds one merge write; query adds a
// step to scale the result. After reset the initial block is written first.
// A finished result waits in an output register while the next item is taken.
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int POOL_UNITS = 1024,
  parameter int UNIT_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [14:0] in_size_bytes,
  input  logic [9:0]  in_block_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [9:0]  out_payload_unit,
  output logic [14:0] out_max_free_bytes
);

  localparam int AW = $clog2(POOL_UNITS);
  localparam int LW = $clog2(POOL_UNITS + 1);
  localparam int HW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int DW = LW + 1;

  ffba_state_t state_r, state_nxt;

  logic [1:0]    mode_r, mode_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [16:0]   need_r, need_nxt;
  logic [AW:0]   s_r, s_nxt;
  logic [LW-1:0] blk_len_r, blk_len_nxt;
  logic [LW-1:0] best_r, best_nxt;
  logic [AW:0]   ps_r, ps_nxt;
  logic [LW-1:0] pl_r, pl_nxt;
  logic          pf_r, pf_nxt, pe_r, pe_nxt;
  logic          nx_ok_r, nx_ok_nxt;
  logic          res_status_r, res_status_nxt;
  logic [9:0]    res_payload_r, res_payload_nxt;
  logic [14:0]   res_max_r, res_max_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [9:0]    out_payload_r, out_payload_nxt;
  logic [14:0]   out_max_r, out_max_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic          div_start, div_done;
  logic [15:0]   div_q;

  logic          in_fire, out_slot;
  logic [LW-1:0] d_len;
  logic          d_free;
  logic [AW+1:0] nxt_s;
  logic          nxt_end;
  logic [HW-1:0] s_ext;
  logic [LW-1:0] base_len;
  logic [AW+11:0] pu_sum;
  logic [LW+8:0] prod;

  assign in_fire  = in_valid && in_ready;
  assign out_slot = !out_valid_r || out_ready;
  assign d_len    = ram_rdata[DW-1:1];
  assign d_free   = ram_rdata[0];
  assign nxt_s    = (AW+2)'(s_r) + (AW+2)'(d_len);
  assign nxt_end  = nxt_s >= (AW+2)'(POOL_UNITS);
  assign s_ext    = HW'(s_r);
  assign pu_sum   = (AW+12)'(s_r) + (AW+12)'(1);
  assign prod     = (LW+9)'(best_r - LW'(1)) * (LW+9)'(UNIT_BYTES);

  assign div_start = in_fire && (in_mode == MODE_ALLOC);

  ffba_div #(.DIVISOR(UNIT_BYTES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (16'(in_size_bytes) + 16'(UNIT_BYTES - 1)),
    .done     (div_done),
    .quotient (div_q)
  );

  ffba_ram #(.WIDTH(DW), .DEPTH(POOL_UNITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_mode)
            MODE_ALLOC: state_nxt = ST_DIV;
            MODE_FREE:  state_nxt = (in_block_unit == 10'd0) ? ST_RESP : ST_WALK;
            MODE_QUERY: state_nxt = ST_WALK;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        unique case (mode_r)
          MODE_ALLOC: begin
            if (d_len == '0) state_nxt = ST_RESP;
            else if (d_free && 17'(d_len) >= need_r) state_nxt = ST_ALLOC_SPLIT;
            else if (nxt_end) state_nxt = ST_RESP;
          end
          MODE_FREE: begin
            if (s_ext == h_r) state_nxt = d_free ? ST_RESP : ST_FREE_MERGE;
            else if (s_ext > h_r || d_len == '0 || nxt_end) state_nxt = ST_RESP;
          end
          default: begin
            if (d_len == '0 || nxt_end) state_nxt = ST_QUERY_FIN;
          end
        endcase
      end
      ST_ALLOC_SPLIT: state_nxt = ST_ALLOC_MARK;
      ST_ALLOC_MARK:  state_nxt = ST_RESP;
      ST_FREE_MERGE:  state_nxt = ST_RESP;
      ST_QUERY_FIN:   state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_slot) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt        = mode_r;
    h_nxt           = h_r;
    need_nxt        = need_r;
    s_nxt           = s_r;
    blk_len_nxt     = blk_len_r;
    best_nxt        = best_r;
    ps_nxt          = ps_r;
    pl_nxt          = pl_r;
    pf_nxt          = pf_r;
    pe_nxt          = pe_r;
    nx_ok_nxt       = nx_ok_r;
    res_status_nxt  = res_status_r;
    res_payload_nxt = res_payload_r;
    res_max_nxt     = res_max_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    out_max_nxt     = out_max_r;
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = '0;
    base_len        = '0;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {LW'(POOL_UNITS), 1'b1};
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          mode_nxt        = in_mode;
          h_nxt           = HW'(in_block_unit - 10'd1);
          s_nxt           = '0;
          best_nxt        = '0;
          pe_nxt          = 1'b0;
          pf_nxt          = 1'b0;
          res_status_nxt  = STATUS_OK;
          res_payload_nxt = '0;
          res_max_nxt     = '0;
        end
      end
      ST_DIV: begin
        need_nxt = 17'(div_q) + 17'd1;
      end
      ST_WALK: begin
        // next block read is issued from this block's length
        ram_raddr = nxt_s[AW-1:0];
        s_nxt     = nxt_s[AW:0];
        unique case (mode_r)
          MODE_ALLOC: begin
            blk_len_nxt = d_len;
            if (d_len == '0 || (!(d_free && 17'(d_len) >= need_r) && nxt_end)) begin
              res_status_nxt = STATUS_NOFIT;
            end
            if (d_free && 17'(d_len) >= need_r) s_nxt = s_r;
          end
          MODE_FREE: begin
            blk_len_nxt = d_len;
            nx_ok_nxt   = !nxt_end;
            ps_nxt      = s_r;
            pl_nxt      = d_len;
            pf_nxt      = d_free;
            pe_nxt      = 1'b1;
            if (s_ext == h_r) begin
              ps_nxt = ps_r;
              pl_nxt = pl_r;
              pf_nxt = pf_r;
              pe_nxt = pe_r;
            end
          end
          default: begin
            if (d_len != '0 && d_free && d_len > best_r) best_nxt = d_len;
          end
        endcase
      end
      ST_ALLOC_SPLIT: begin
        // remainder becomes a new free block
        if (blk_len_r > need_r[LW-1:0]) begin
          ram_we    = 1'b1;
          ram_waddr = s_r[AW-1:0] + need_r[AW-1:0];
          ram_wdata = {blk_len_r - need_r[LW-1:0], 1'b1};
        end
      end
      ST_ALLOC_MARK: begin
        ram_we          = 1'b1;
        ram_waddr       = s_r[AW-1:0];
        ram_wdata       = {need_r[LW-1:0], 1'b0};
        res_payload_nxt = pu_sum[9:0];
      end
      ST_FREE_MERGE: begin
        base_len = ((pe_r && pf_r) ? pl_r : LW'(0)) + blk_len_r;
        if (nx_ok_r && d_free) base_len = base_len + d_len;
        ram_we    = 1'b1;
        ram_waddr = (pe_r && pf_r) ? ps_r[AW-1:0] : h_r[AW-1:0];
        ram_wdata = {base_len, 1'b1};
      end
      ST_QUERY_FIN: begin
        if (best_r == '0) res_max_nxt = '0;
        else if (prod > (LW+9)'(MAX_BYTES_SAT)) res_max_nxt = MAX_BYTES_SAT;
        else res_max_nxt = prod[14:0];
      end
      ST_RESP: begin
        if (out_slot) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_payload_nxt = res_payload_r;
          out_max_nxt     = res_max_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r        <= mode_nxt;
    h_r           <= h_nxt;
    need_r        <= need_nxt;
    s_r           <= s_nxt;
    blk_len_r     <= blk_len_nxt;
    best_r        <= best_nxt;
    ps_r          <= ps_nxt;
    pl_r          <= pl_nxt;
    pf_r          <= pf_nxt;
    pe_r          <= pe_nxt;
    nx_ok_r       <= nx_ok_nxt;
    res_status_r  <= res_status_nxt;
    res_payload_r <= res_payload_nxt;
    res_max_r     <= res_max_nxt;
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
    out_max_r     <= out_max_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_unit   = out_payload_r;
  assign out_max_free_bytes = out_max_r;

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !ram_we)
    else $error("header write during list walk");

  a_no_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_wdata[DW-1:1] != '0))
    else $error("zero-length block header written");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted item did not start work");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator.
// ---------------------------------------------------------------------------
// A shadow copy of the block list predicts each allocate, free and
// largest-free query as its item is queued. A driver sends the queued items
// and a monitor compares every result beat with the oldest prediction.
// Traffic is a directed opening followed by three random phases with
// different amounts of idling on each side, one long output stall, and a
// drain of all outstanding results between phases.
// ---------------------------------------------------------------------------
module tb_top
  import ffba_pkg::*;
;

  localparam int POOL = 1024;
  localparam int UBYTES = 32;
  localparam int PHASE_ITEMS = 384;
  localparam int LONG_HOLD = 3000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [14:0] size;
    logic [9:0]  unit;
  } alloc_req_t;

  typedef struct {
    logic        status;
    logic [9:0]  payload;
    logic [14:0] max_bytes;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_QUERY;
  logic [14:0] in_size_bytes = '0;
  logic [9:0]  in_block_unit = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [9:0]  out_payload_unit;
  logic [14:0] out_max_free_bytes;

  first_fit_block_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_size_bytes(in_size_bytes), .in_block_unit(in_block_unit),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_payload_unit(out_payload_unit), .out_max_free_bytes(out_max_free_bytes)
  );

  always #10 clk = ~clk;

  // shadow block list, indexed by block start unit
  int unsigned blk_len[POOL];
  bit          blk_free[POOL];
  int unsigned blk_prev[POOL];
  bit          blk_prev_ok[POOL];
  bit          blk_written[POOL];

  alloc_req_t  pending_reqs[$];
  alloc_rsp_t  expected_rsps[$];
  int unsigned live_payloads[$];

  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic        in_taken = 1'b0;

  function automatic void pool_reset();
    for (int i = 0; i < POOL; i++) begin
      blk_len[i] = 0;
      blk_free[i] = 0;
      blk_prev[i] = 0;
      blk_prev_ok[i] = 0;
      blk_written[i] = 0;
    end
    blk_len[0] = POOL;
    blk_free[0] = 1;
    blk_written[0] = 1;
  endfunction

  function automatic void link_left(int unsigned at, int unsigned left);
    if (at < POOL) begin
      blk_prev[at] = left;
      blk_prev_ok[at] = 1;
    end
  endfunction

  function automatic bit is_used_start(int unsigned h);
    int unsigned s;
    s = 0;
    while (s < POOL) begin
      if (s == h) return !blk_free[s];
      if (s > h || blk_len[s] == 0) return 0;
      s += blk_len[s];
    end
    return 0;
  endfunction

  // applies one item to the shadow list and returns the result it causes
  function automatic alloc_rsp_t pool_apply(alloc_req_t r);
    alloc_rsp_t  o;
    int unsigned need, s, len, h, p, nx;
    o = '{STATUS_OK, 10'd0, 15'd0};
    if (r.mode == MODE_ALLOC) begin
      need = (int'(r.size) + UBYTES - 1) / UBYTES + 1;
      o.status = STATUS_NOFIT;
      s = 0;
      while (s < POOL && blk_len[s] != 0) begin
        len = blk_len[s];
        if (blk_free[s] && len >= need) begin
          if (len > need) begin
            blk_len[s + need] = len - need;
            blk_free[s + need] = 1;
            blk_written[s + need] = 1;
            link_left(s + need, s);
            link_left(s + len, s + need);
          end
          blk_len[s] = need;
          blk_free[s] = 0;
          o.status = STATUS_OK;
          o.payload = 10'((s + 1) % POOL);
          break;
        end
        s += len;
      end
    end else if (r.mode == MODE_FREE) begin
      if (r.unit != 0 && is_used_start(r.unit - 1)) begin
        h = r.unit - 1;
        blk_free[h] = 1;
        if (blk_prev_ok[h]) begin
          p = blk_prev[h];
          if (p < POOL && blk_free[p]) begin
            link_left(h + blk_len[h], p);
            blk_len[p] += blk_len[h];
            h = p;
          end
        end
        nx = h + blk_len[h];
        if (nx < POOL && blk_free[nx]) begin
          link_left(nx + blk_len[nx], h);
          blk_len[h] += blk_len[nx];
        end
      end
    end else if (r.mode == MODE_QUERY) begin
      len = 0;
      s = 0;
      while (s < POOL && blk_len[s] != 0) begin
        if (blk_free[s] && blk_len[s] > len) len = blk_len[s];
        s += blk_len[s];
      end
      if (len != 0)
        o.max_bytes = ((len - 1) * UBYTES > 32767) ? MAX_BYTES_SAT : 15'((len - 1) * UBYTES);
    end
    return o;
  endfunction

  task automatic queue_item(logic [1:0] mode, logic [14:0] size, logic [9:0] unit);
    alloc_req_t  r;
    alloc_rsp_t  o;
    bit          freeing;
    r = '{mode, size, unit};
    freeing = (mode == MODE_FREE) && unit != 0 && is_used_start(unit - 1);
    o = pool_apply(r);
    if (freeing) begin
      foreach (live_payloads[i])
        if (live_payloads[i] == unit) begin
          live_payloads.delete(i);
          break;
        end
    end
    // a payload that wrapped to unit 0 can never be freed
    if (mode == MODE_ALLOC && o.status == STATUS_OK && o.payload != 0)
      live_payloads.push_back(o.payload);
    pending_reqs.push_back(r);
    expected_rsps.push_back(o);
  endtask

  task automatic queue_random_item();
    int unsigned pick, u;
    logic [14:0] sz;
    pick = $urandom_range(0, 99);
    if (live_payloads.size() > 40) pick = (pick < 50) ? 50 : pick;
    if (pick < 48) begin
      u = $urandom_range(0, 99);
      if (u < 60)      sz = 15'($urandom_range(0, 200));
      else if (u < 85) sz = 15'($urandom_range(0, 2000));
      else if (u < 95) sz = 15'($urandom_range(0, 8000));
      else             sz = 15'($urandom);
      queue_item(MODE_ALLOC, sz, 10'($urandom));
    end else if (pick < 88) begin
      if (live_payloads.size() > 0 && $urandom_range(0, 99) < 75) begin
        u = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
      end else begin
        // mostly bad frees: unit zero, a double free or a unit that is no block start
        u = 0;
        for (int t = 0; t < 20; t++) begin
          pick = $urandom_range(1, POOL - 1);
          if (blk_written[pick - 1]) begin
            u = pick;
            break;
          end
        end
      end
      queue_item(MODE_FREE, 15'($urandom), 10'(u));
    end else if (pick < 97) begin
      queue_item(MODE_QUERY, 15'($urandom), 10'($urandom));
    end else begin
      queue_item(MODE_UNUSED, 15'($urandom), 10'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    alloc_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_mode <= r.mode;
        in_size_bytes <= r.size;
        in_block_unit <= r.unit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with its own count for the long stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    alloc_rsp_t e;
    in_taken <= in_valid && in_ready;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        e = expected_rsps.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_payload_unit !== e.payload)
          report("payload_unit", out_payload_unit, e.payload);
        if (out_max_free_bytes !== e.max_bytes)
          report("max_free_bytes", out_max_free_bytes, e.max_bytes);
      end
    end
  end

  initial begin
    pool_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: whole pool, empty pool, wrapped payload, bad frees, unused mode
    queue_item(MODE_QUERY, 15'h7fff, 10'h3ff);
    queue_item(MODE_ALLOC, 15'd32736, 10'h3ff);
    queue_item(MODE_QUERY, 15'd0, 10'd0);
    queue_item(MODE_ALLOC, 15'd1, 10'd0);
    queue_item(MODE_FREE, 15'd0, 10'd1);
    queue_item(MODE_ALLOC, 15'(32 * 1021), 10'd0);
    queue_item(MODE_ALLOC, 15'd0, 10'd0);
    queue_item(MODE_ALLOC, 15'd0, 10'd0);
    queue_item(MODE_QUERY, 15'd0, 10'd0);
    queue_item(MODE_FREE, 15'h7fff, 10'd0);
    queue_item(MODE_FREE, 15'd0, 10'd1);
    queue_item(MODE_FREE, 15'd0, 10'd1);
    queue_item(MODE_FREE, 15'd0, 10'd1023);
    queue_item(MODE_FREE, 15'd0, 10'd1023);
    queue_item(MODE_QUERY, 15'd0, 10'd0);
    queue_item(MODE_UNUSED, 15'h7fff, 10'h3ff);
    queue_item(MODE_ALLOC, 15'h7fff, 10'h3ff);
    queue_item(MODE_ALLOC, 15'd33, 10'd0);
    queue_item(MODE_ALLOC, 15'd32, 10'd0);
    queue_item(MODE_FREE, 15'd0, 10'd1);
    queue_item(MODE_QUERY, 15'd0, 10'd0);
    wait_drained();

    tx_idle_pct = 31;
    rx_idle_pct = 79;
    repeat (PHASE_ITEMS) queue_random_item();
    wait_drained();

    tx_idle_pct = 79;
    rx_idle_pct = 31;
    repeat (PHASE_ITEMS) queue_random_item();
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PHASE_ITEMS) queue_random_item();
    hold_requests++;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
